// File: sv/bsl_pkg.sv
// shared types and constants for the bit-timed serial link
package bsl_pkg;

  localparam int unsigned TICK_W        = 10;
  localparam int unsigned EXTRA_W       = 4;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 10;
  localparam int unsigned DATA_BITS_DEF = 8;

  localparam logic [TICK_W-1:0]  BIT_TICKS_RST   = TICK_W'(30);
  localparam logic [EXTRA_W-1:0] FIRST_EXTRA_RST = EXTRA_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 3'd0,
    OP_SEND = 3'd1,
    OP_RECV = 3'd2,
    OP_EXIT = 3'd3,
    OP_SET  = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_TICKS   = 1'd0,
    REG_FIRST_EXTRA = 1'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_TX_PRE   = 4'd1,
    PH_TX_START = 4'd2,
    PH_TX_DATA  = 4'd3,
    PH_TX_STOP  = 4'd4,
    PH_RX_WAIT  = 4'd5,
    PH_RX_EXTRA = 4'd6,
    PH_RX_BIT   = 4'd7,
    PH_RX_FINAL = 4'd8
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0]  bit_ticks;
    logic [EXTRA_W-1:0] first_sample_extra;
  } cfg_t;

  typedef struct packed {
    logic              line_out;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_done;
    logic              tx_done;
    logic              busy_res;
    logic              rejected;
  } res_t;

endpackage

// File: sv/bsl_if.sv
// channel interfaces for op items and link results
interface bsl_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       line_in;

  modport source (output valid, op, tx_byte, line_in, input ready);
  modport sink   (input valid, op, tx_byte, line_in, output ready);
endinterface

interface bsl_res_if;
  logic       valid;
  logic       ready;
  logic       line_out;
  logic [7:0] rx_byte;
  logic       rx_done;
  logic       tx_done;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, line_out, rx_byte, rx_done, tx_done, busy_res, rejected,
                  input ready);
  modport sink   (input valid, line_out, rx_byte, rx_done, tx_done, busy_res, rejected,
                  output ready);
endinterface

// File: sv/bsl_cfg.sv
// configuration registers: bit period and first sample offset
module bsl_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bsl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsl_pkg::CFG_DATA_W-1:0]      cfg_data,
  output bsl_pkg::cfg_t                       cfg
);
  import bsl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_ticks          <= BIT_TICKS_RST;
      cfg.first_sample_extra <= FIRST_EXTRA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_TICKS:   cfg.bit_ticks          <= cfg_data[TICK_W-1:0];
        REG_FIRST_EXTRA: cfg.first_sample_extra <= cfg_data[EXTRA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/bsl_core.sv
// link engine: state registers and next-state logic for one item per cycle while fire is high
module bsl_core #(
  parameter int unsigned DATA_BITS = bsl_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bsl_pkg::cfg_t                 cfg,
  input  logic                          fire,
  input  logic [bsl_pkg::OP_W-1:0]      op,
  input  logic [bsl_pkg::BYTE_W-1:0]    tx_byte,
  input  logic                          line_in,
  output bsl_pkg::res_t                 res
);
  import bsl_pkg::*;

  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [IDX_W-1:0]    bit_index, bit_index_next;
  logic [BYTE_W-1:0]   shift_byte, shift_byte_next;
  logic                line_level, line_level_next;
  logic                exit_flag, exit_flag_next;

  logic [TICK_W-1:0]   tick_inc;
  logic                done_bt, done_extra, last_bit;

  assign tick_inc   = tick_count + 1'b1;
  // a zero period behaves as one tick since the compare always passes
  assign done_bt    = tick_inc >= cfg.bit_ticks;
  assign done_extra = tick_inc >= TICK_W'(cfg.first_sample_extra);
  assign last_bit   = ({1'b0, bit_index} + 1'b1) >= (IDX_W+1)'(DATA_BITS);

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    line_level_next = line_level;
    exit_flag_next  = exit_flag;
    res             = '0;

    case (op)
      OP_SEND, OP_RECV: begin
        if (phase != PH_IDLE) begin
          res.rejected = 1'b1;
        end else if (op == OP_SEND) begin
          shift_byte_next = tx_byte;
          phase_next      = PH_TX_PRE;
          tick_count_next = '0;
        end else begin
          shift_byte_next = '0;
          tick_count_next = '0;
          if (!exit_flag) begin
            phase_next = PH_RX_WAIT;
          end else if (cfg.first_sample_extra == '0) begin
            phase_next     = PH_RX_BIT;
            bit_index_next = '0;
          end else begin
            phase_next = PH_RX_EXTRA;
          end
        end
      end
      OP_EXIT: exit_flag_next = 1'b1;
      OP_SET:  exit_flag_next = 1'b0;
      OP_TICK: begin
        case (phase)
          PH_IDLE: ;
          PH_TX_PRE: begin
            tick_count_next = done_bt ? '0 : tick_inc;
            if (done_bt) begin
              line_level_next = 1'b0;
              phase_next      = PH_TX_START;
            end
          end
          PH_TX_START: begin
            tick_count_next = done_bt ? '0 : tick_inc;
            if (done_bt) begin
              line_level_next = shift_byte[BYTE_W-1];
              shift_byte_next = {shift_byte[BYTE_W-2:0], 1'b0};
              bit_index_next  = '0;
              phase_next      = PH_TX_DATA;
            end
          end
          PH_TX_DATA: begin
            tick_count_next = done_bt ? '0 : tick_inc;
            if (done_bt) begin
              if (last_bit) begin
                line_level_next = 1'b1;
                phase_next      = PH_TX_STOP;
              end else begin
                line_level_next = shift_byte[BYTE_W-1];
                shift_byte_next = {shift_byte[BYTE_W-2:0], 1'b0};
                bit_index_next  = bit_index + 1'b1;
              end
            end
          end
          PH_TX_STOP: begin
            tick_count_next = done_bt ? '0 : tick_inc;
            if (done_bt) begin
              res.tx_done = 1'b1;
              phase_next  = PH_IDLE;
            end
          end
          PH_RX_WAIT: begin
            if (!line_in || exit_flag) begin
              tick_count_next = '0;
              if (cfg.first_sample_extra == '0) begin
                phase_next     = PH_RX_BIT;
                bit_index_next = '0;
              end else begin
                phase_next = PH_RX_EXTRA;
              end
            end
          end
          PH_RX_EXTRA: begin
            tick_count_next = done_extra ? '0 : tick_inc;
            if (done_extra) begin
              phase_next     = PH_RX_BIT;
              bit_index_next = '0;
            end
          end
          PH_RX_BIT: begin
            tick_count_next = done_bt ? '0 : tick_inc;
            if (done_bt) begin
              shift_byte_next = {shift_byte[BYTE_W-2:0], line_in};
              if (last_bit) phase_next = PH_RX_FINAL;
              else          bit_index_next = bit_index + 1'b1;
            end
          end
          PH_RX_FINAL: begin
            tick_count_next = done_bt ? '0 : tick_inc;
            if (done_bt) begin
              res.rx_done = 1'b1;
              res.rx_byte = shift_byte;
              phase_next  = PH_IDLE;
            end
          end
          default: begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
        endcase
      end
      default: ;
    endcase

    res.line_out = line_level_next;
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      line_level <= 1'b1;
      exit_flag  <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      line_level <= line_level_next;
      exit_flag  <= exit_flag_next;
    end
  end

endmodule

// File: sv/bsl_skid.sv
// two-entry result register; ready upstream comes from a flop
module bsl_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bsl_pkg::res_t  din,
  output logic           up_ready,
  output logic           dn_valid,
  input  logic           dn_ready,
  output bsl_pkg::res_t  dout
);
  import bsl_pkg::*;

  logic main_valid, skid_valid;
  res_t main_data, skid_data;
  logic pop;

  assign up_ready = !skid_valid;
  assign dn_valid = main_valid;
  assign dout     = main_data;
  assign pop      = main_valid && dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) main_valid <= 1'b1;
      else             skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_data <= skid_valid ? skid_data : din;
    end else if (push) begin
      if (!main_valid) main_data <= din;
      else             skid_data <= din;
    end
  end

endmodule

// File: sv/bit_timed_serial_link.sv
// bit-timed serial link top level
//
// item channel: one op per transfer (tick, send, receive, exit, set), with the
// tx byte and the sampled receive line level. time advances on tick ops only,
// so the bit period is bit_ticks tick transfers, not clock cycles.
// result channel: one result per item (line level, received byte and done
// flags, busy and rejected), taken after the item is applied.
// the result of an item is registered before it reaches the result channel.
// one item per cycle while item ready is high; the engine state updates in the cycle of
// the transfer through one pass of next-state logic.
// a two-entry result register sits in front of the result channel; item ready
// drops only when both entries hold results, and no result is ever dropped.
// configuration: register 0 bit_ticks, register 1 first_sample_extra, written
// through cfg_we / cfg_index / cfg_data; the user must write them only while the
// link is idle, which the block does not enforce. reset: phase idle, line high,
// exit flag clear, registers at 30 and 1, both result entries empty; item ready stays low while rst is high.
module bit_timed_serial_link #(
  parameter int unsigned DATA_BITS = bsl_pkg::DATA_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  bsl_item_if.sink                         item,
  bsl_res_if.source                        result,
  input  logic                             cfg_we,
  input  logic [bsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bsl_pkg::*;

  cfg_t cfg;
  res_t res_next, res_out;
  logic fire, up_ready;

  // no item is taken while the link is held in reset
  assign item.ready = up_ready && !rst;
  assign fire       = item.valid && up_ready && !rst;

  bsl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bsl_core #(
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .op      (item.op),
    .tx_byte (item.tx_byte),
    .line_in (item.line_in),
    .res     (res_next)
  );

  bsl_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .din      (res_next),
    .up_ready (up_ready),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .dout     (res_out)
  );

  assign result.line_out = res_out.line_out;
  assign result.rx_byte  = res_out.rx_byte;
  assign result.rx_done  = res_out.rx_done;
  assign result.tx_done  = res_out.tx_done;
  assign result.busy_res = res_out.busy_res;
  assign result.rejected = res_out.rejected;

endmodule

// File: sv/bsl_checker.sv
// port-level checks for the serial link, bound to the top level
module bsl_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       line_out,
  input logic [7:0] rx_byte,
  input logic       rx_done,
  input logic       tx_done,
  input logic       busy_res,
  input logic       rejected
);

  // a send and a receive never finish on the same item
  a_done_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(rx_done && tx_done))
    else $error("rx_done and tx_done together");

  a_rx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !rx_done) |-> (rx_byte == 8'd0))
    else $error("rx_byte nonzero without rx_done");

  // a rejected op leaves the engine in its transfer
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && rejected) |-> busy_res)
    else $error("rejected while not busy");

  a_tx_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && tx_done) |-> (!busy_res && line_out))
    else $error("tx end with busy or line low");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(rx_byte) && $stable(busy_res)))
    else $error("stalled result changed");

endmodule

bind bit_timed_serial_link bsl_checker u_bsl_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .line_out  (result.line_out),
  .rx_byte   (result.rx_byte),
  .rx_done   (result.rx_done),
  .tx_done   (result.tx_done),
  .busy_res  (result.busy_res),
  .rejected  (result.rejected)
);
